[rtl/vlrf_pkg.sv]
package vlrf_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_MAX_DIM    = 32;
    localparam int DEF_MAX_RADIUS = 7;
    localparam int DEF_VALUE_BITS = 16;

    // Fixed field widths of the channels and registers.
    localparam int POS_W      = 5;
    localparam int SIZE_W     = 6;
    localparam int RAD_W      = 3;
    localparam int CNT_W      = 12;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Size register value after reset, before saturation to the volume.
    localparam int SIZE_RST_RAW = 32;
    localparam int RAD_RST      = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X        = 2'd0,
        CFG_SIZE_Y        = 2'd1,
        CFG_SIZE_Z        = 2'd2,
        CFG_WINDOW_RADIUS = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTRE,
        S_SWEEP,
        S_DRAIN,
        S_DIVIDE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic capture;     // input item accepted, latch it
        logic ram_we;      // store the voxel of a good write item
        logic rd_centre;   // read the centre voxel
        logic sweep;       // read the current window voxel and advance
        logic div_step;    // one quotient bit
        logic div_first;   // first quotient bit, start from the below count
        logic load_result; // move the finished result to the output register
    } t_ctrl_cmd;

    typedef struct packed {
        logic coord_ok;    // input coordinate lies inside the volume
        logic is_eval;     // input item is an evaluate
        logic sweep_last;  // current window voxel is the last one
        logic out_free;    // output register can take a result this cycle
    } t_dp_status;

endpackage

[rtl/vlrf_in_if.sv]
interface vlrf_in_if
    import vlrf_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [POS_W-1:0]      pos_z;
    logic [VALUE_BITS-1:0] voxel_value;

    modport source (
        output valid, cmd, pos_x, pos_y, pos_z, voxel_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, pos_x, pos_y, pos_z, voxel_value,
        output ready
    );
endinterface

[rtl/vlrf_out_if.sv]
interface vlrf_out_if
    import vlrf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FRAC_W-1:0] rank_fraction;
    logic [CNT_W-1:0]  below_count;
    logic [CNT_W-1:0]  window_size;
    logic              bad_coord;

    modport source (
        output valid, rank_fraction, below_count, window_size, bad_coord,
        input  ready
    );

    modport sink (
        input  valid, rank_fraction, below_count, window_size, bad_coord,
        output ready
    );
endinterface

[rtl/vlrf_ram.sv]
module vlrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/vlrf_ctrl.sv]
module vlrf_ctrl
    import vlrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);
    localparam int DIV_CNT_W = $clog2(FRAC_W);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 accept;
    logic                 div_last;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign div_last = (r_div_cnt == DIV_CNT_W'(FRAC_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_status.coord_ok) begin
                        n_state = S_RESULT;
                    end else if (i_status.is_eval) begin
                        n_state = S_CENTRE;
                    end
                end
            end
            S_CENTRE: n_state = S_SWEEP;
            S_SWEEP: begin
                if (i_status.sweep_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state   = S_DIVIDE;
                n_div_cnt = '0;
            end
            S_DIVIDE: begin
                n_div_cnt = r_div_cnt + 1'b1;
                if (div_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = accept;
                o_cmd.ram_we  = accept && i_status.coord_ok && !i_status.is_eval;
            end
            S_CENTRE: o_cmd.rd_centre = 1'b1;
            S_SWEEP:  o_cmd.sweep     = 1'b1;
            S_DRAIN:  ;
            S_DIVIDE: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_div_cnt == '0);
            end
            S_RESULT: o_cmd.load_result = i_status.out_free;
            default:  ;
        endcase
    end
endmodule

[rtl/vlrf_dp.sv]
module vlrf_dp
    import vlrf_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_cmd,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [POS_W-1:0]      i_pos_z,
    input  logic [VALUE_BITS-1:0] i_voxel_value,
    input  t_ctrl_cmd             i_ctl,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [FRAC_W-1:0]     o_rank_fraction,
    output logic [CNT_W-1:0]      o_below_count,
    output logic [CNT_W-1:0]      o_window_size,
    output logic                  o_bad_coord
);
    // A size register holds at most 63, so no window coordinate reaches beyond that.
    localparam int DIM_CAP  = (MAX_DIM < 63) ? MAX_DIM : 63;
    localparam int RAD_CAP  = (MAX_RADIUS < 7) ? MAX_RADIUS : 7;
    localparam int AXIS_W   = $clog2(DIM_CAP);
    localparam int ADDR_W   = 3 * AXIS_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int SPAN_W   = 7;
    localparam int SIZE_RST = (SIZE_RST_RAW > DIM_CAP) ? DIM_CAP : SIZE_RST_RAW;

    function automatic logic [AXIS_W-1:0] span_lo(
        input logic [POS_W-1:0] c,
        input logic [RAD_W-1:0] r
    );
        logic [SPAN_W-1:0] c7;
        logic [SPAN_W-1:0] r7;
        logic [SPAN_W-1:0] lo;
        c7 = SPAN_W'(c);
        r7 = SPAN_W'(r);
        lo = (c7 > r7) ? c7 - r7 : '0;
        return lo[AXIS_W-1:0];
    endfunction

    function automatic logic [AXIS_W-1:0] span_hi(
        input logic [POS_W-1:0]  c,
        input logic [RAD_W-1:0]  r,
        input logic [SIZE_W-1:0] n
    );
        logic [SPAN_W-1:0] sum;
        logic [SPAN_W-1:0] n7;
        logic [SPAN_W-1:0] hi;
        sum = SPAN_W'(c) + SPAN_W'(r);
        n7  = SPAN_W'(n);
        hi  = (sum >= n7) ? n7 - 1'b1 : sum;
        return hi[AXIS_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] sat_dim(input logic [SIZE_W-1:0] v);
        return (int'(v) > DIM_CAP) ? SIZE_W'(DIM_CAP) : v;
    endfunction

    function automatic logic [AXIS_W-1:0] to_axis(input logic [POS_W-1:0] p);
        logic [SPAN_W-1:0] p7;
        p7 = SPAN_W'(p);
        return p7[AXIS_W-1:0];
    endfunction

    // Configuration registers.
    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [RAD_W-1:0]  r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_W'(SIZE_RST);
            r_size_y <= SIZE_W'(SIZE_RST);
            r_size_z <= SIZE_W'(SIZE_RST);
            r_radius <= RAD_W'(RAD_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_SIZE_X: r_size_x <= sat_dim(i_cfg_data);
                CFG_SIZE_Y: r_size_y <= sat_dim(i_cfg_data);
                CFG_SIZE_Z: r_size_z <= sat_dim(i_cfg_data);
                CFG_WINDOW_RADIUS: begin
                    r_radius <= (int'(i_cfg_data[RAD_W-1:0]) > RAD_CAP)
                        ? RAD_W'(RAD_CAP) : i_cfg_data[RAD_W-1:0];
                end
                default: ;
            endcase
        end
    end

    logic coord_ok;
    assign coord_ok = (SIZE_W'(i_pos_x) < r_size_x) && (SIZE_W'(i_pos_y) < r_size_y)
                   && (SIZE_W'(i_pos_z) < r_size_z);

    // Item registers: centre coordinate, window bounds and sweep counters.
    logic [AXIS_W-1:0] r_px, r_py, r_pz;
    logic [AXIS_W-1:0] r_x0, r_x1, r_y0, r_y1, r_z0, r_z1;
    logic [AXIS_W-1:0] r_cx, r_cy, r_cz;
    logic              r_bad;
    logic [CNT_W-1:0]  r_win;
    logic [CNT_W-1:0]  r_below;
    logic              sweep_last;

    assign sweep_last = (r_cx == r_x1) && (r_cy == r_y1) && (r_cz == r_z1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_bad <= !coord_ok;
            r_px  <= to_axis(i_pos_x);
            r_py  <= to_axis(i_pos_y);
            r_pz  <= to_axis(i_pos_z);
            r_x0  <= span_lo(i_pos_x, r_radius);
            r_y0  <= span_lo(i_pos_y, r_radius);
            r_z0  <= span_lo(i_pos_z, r_radius);
            r_x1  <= span_hi(i_pos_x, r_radius, r_size_x);
            r_y1  <= span_hi(i_pos_y, r_radius, r_size_y);
            r_z1  <= span_hi(i_pos_z, r_radius, r_size_z);
            r_cx  <= span_lo(i_pos_x, r_radius);
            r_cy  <= span_lo(i_pos_y, r_radius);
            r_cz  <= span_lo(i_pos_z, r_radius);
            r_win <= '0;
        end else if (i_ctl.sweep) begin
            // Raster order: x fastest, then y, then z.
            r_win <= r_win + 1'b1;
            if (r_cx == r_x1) begin
                r_cx <= r_x0;
                if (r_cy == r_y1) begin
                    r_cy <= r_y0;
                    r_cz <= r_cz + 1'b1;
                end else begin
                    r_cy <= r_cy + 1'b1;
                end
            end else begin
                r_cx <= r_cx + 1'b1;
            end
        end
    end

    // Voxel store.
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [VALUE_BITS-1:0] rdata;

    assign waddr = {to_axis(i_pos_z), to_axis(i_pos_y), to_axis(i_pos_x)};
    assign raddr = i_ctl.rd_centre ? {r_pz, r_py, r_px} : {r_cz, r_cy, r_cx};

    vlrf_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.ram_we),
        .i_waddr (waddr),
        .i_wdata (i_voxel_value),
        .i_re    (i_ctl.rd_centre || i_ctl.sweep),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Read data arrives in the cycle after its address, so the kind of read follows it.
    logic                         r_tag_centre, r_tag_voxel;
    logic signed [VALUE_BITS-1:0] r_centre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_centre <= 1'b0;
            r_tag_voxel  <= 1'b0;
        end else begin
            r_tag_centre <= i_ctl.rd_centre;
            r_tag_voxel  <= i_ctl.sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_below <= '0;
        end else if (r_tag_voxel && ($signed(rdata) < r_centre)) begin
            r_below <= r_below + 1'b1;
        end
        if (r_tag_centre) begin
            r_centre <= $signed(rdata);
        end
    end

    // Restoring division, one quotient bit per cycle. The remainder stays below
    // the window size, so below * 2^16 / window fits the quotient register.
    logic [CNT_W-1:0]  r_rem;
    logic [FRAC_W-1:0] r_quot;
    logic [CNT_W-1:0]  rem_base;
    logic [CNT_W:0]    rem_sh;
    logic              rem_ge;
    logic [CNT_W:0]    rem_nx;

    assign rem_base = i_ctl.div_first ? r_below : r_rem;
    assign rem_sh   = {rem_base, 1'b0};
    assign rem_ge   = (rem_sh >= {1'b0, r_win});
    assign rem_nx   = rem_ge ? rem_sh - {1'b0, r_win} : rem_sh;

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_step) begin
            r_rem  <= rem_nx[CNT_W-1:0];
            r_quot <= {r_quot[FRAC_W-2:0], rem_ge};
        end
    end

    // Output register.
    logic              r_out_valid;
    logic [FRAC_W-1:0] r_out_frac;
    logic [CNT_W-1:0]  r_out_below;
    logic [CNT_W-1:0]  r_out_win;
    logic              r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_result) begin
            r_out_bad   <= r_bad;
            r_out_frac  <= r_bad ? '0 : r_quot;
            r_out_below <= r_bad ? '0 : r_below;
            r_out_win   <= r_bad ? '0 : r_win;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rank_fraction = r_out_frac;
    assign o_below_count   = r_out_below;
    assign o_window_size   = r_out_win;
    assign o_bad_coord     = r_out_bad;

    assign o_status.coord_ok   = coord_ok;
    assign o_status.is_eval    = i_cmd;
    assign o_status.sweep_last = sweep_last;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
endmodule

[rtl/volume_local_rank_fraction.sv]
// Local rank fraction over a stored 3D voxel volume. A write item stores one
// signed voxel in an on-chip memory of MAX_DIM (capped at 63) cubed entries
// (rounded up to a power of two per axis) without leaving the idle state; an
// evaluate item reads the centre voxel and then every voxel of the clipped cube
// window once, through the single read port of that memory, counts those
// strictly below the centre, and divides by the window size with a bit-serial
// divider. An item with a coordinate outside the configured size returns only
// the bad_coord flag. Items are handled one at a time, and a finished result
// waits in an output register while the next item is taken.
// A voxel must be written before any window that covers it is evaluated.
// There is no clearing pass after reset.
module volume_local_rank_fraction
    import vlrf_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    vlrf_in_if.sink               i_in,
    vlrf_out_if.source            o_out
);
    t_ctrl_cmd  ctl;
    t_dp_status status;

    vlrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (ctl)
    );

    vlrf_dp #(
        .MAX_DIM    (MAX_DIM),
        .MAX_RADIUS (MAX_RADIUS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_in.cmd),
        .i_pos_x         (i_in.pos_x),
        .i_pos_y         (i_in.pos_y),
        .i_pos_z         (i_in.pos_z),
        .i_voxel_value   (i_in.voxel_value),
        .i_ctl           (ctl),
        .o_status        (status),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_rank_fraction (o_out.rank_fraction),
        .o_below_count   (o_out.below_count),
        .o_window_size   (o_out.window_size),
        .o_bad_coord     (o_out.bad_coord)
    );
endmodule

[rtl/vlrf_checker.sv]
module vlrf_checker
    import vlrf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [FRAC_W-1:0] i_rank_fraction,
    input logic [CNT_W-1:0]  i_below_count,
    input logic [CNT_W-1:0]  i_window_size,
    input logic              i_bad_coord
);
    localparam int MAX_WINDOW = 3375;

    // A result for a bad coordinate carries nothing but the flag.
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_coord |->
            i_rank_fraction == '0 && i_below_count == '0 && i_window_size == '0)
        else $error("bad coordinate result with nonzero fields");

    // The centre voxel is never below itself, so the count stays under the size.
    a_below_lt_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_bad_coord |->
            i_window_size != '0 && i_below_count < i_window_size)
        else $error("below count not under window size");

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_window_size <= CNT_W'(MAX_WINDOW))
        else $error("window size beyond the largest cube");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_rank_fraction) && $stable(i_below_count)
            && $stable(i_window_size) && $stable(i_bad_coord))
        else $error("stalled result item changed");
endmodule

bind volume_local_rank_fraction vlrf_checker u_vlrf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_rank_fraction (o_out.rank_fraction),
    .i_below_count   (o_out.below_count),
    .i_window_size   (o_out.window_size),
    .i_bad_coord     (o_out.bad_coord)
);

[verif/vlrf_tb_pkg.sv]
package vlrf_tb_pkg;

    typedef enum logic {
        CMD_WRITE    = 1'b0,
        CMD_EVALUATE = 1'b1
    } t_voxel_cmd;

endpackage

[verif/vlrf_rank_checker.sv]
module vlrf_rank_checker
    import vlrf_pkg::*;
    import vlrf_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    vlrf_in_if                    i_in,
    vlrf_out_if                   i_out,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM        = DEF_MAX_DIM;
    localparam int DEPTH      = DIM * DIM * DIM;

    typedef struct packed {
        logic [FRAC_W-1:0] rank_fraction;
        logic [CNT_W-1:0]  below_count;
        logic [CNT_W-1:0]  window_size;
        logic              bad_coord;
    } t_rank_result;

    logic signed [DEF_VALUE_BITS-1:0] voxel_mem [DEPTH];
    int unsigned  dim_x, dim_y, dim_z, radius;
    t_rank_result expected_ranks [$];
    int           errors = 0;
    int           open_count = 0;

    assign o_errors  = errors;
    assign o_pending = open_count;

    function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v);
        return (v > DIM) ? DIM : v;
    endfunction

    function automatic int unsigned voxel_addr(int unsigned x, int unsigned y, int unsigned z);
        return x + DIM * (y + DIM * z);
    endfunction

    // Counts the clipped window voxels strictly below the centre value.
    function automatic t_rank_result rank_of_voxel(int unsigned px, int unsigned py,
                                                   int unsigned pz);
        int unsigned x0, x1, y0, y1, z0, z1;
        int unsigned below, count;
        logic signed [DEF_VALUE_BITS-1:0] centre;
        t_rank_result res;
        x0 = (px > radius) ? px - radius : 0;
        x1 = (px + radius >= dim_x) ? dim_x - 1 : px + radius;
        y0 = (py > radius) ? py - radius : 0;
        y1 = (py + radius >= dim_y) ? dim_y - 1 : py + radius;
        z0 = (pz > radius) ? pz - radius : 0;
        z1 = (pz + radius >= dim_z) ? dim_z - 1 : pz + radius;
        centre = voxel_mem[voxel_addr(px, py, pz)];
        below = 0;
        for (int unsigned z = z0; z <= z1; z++) begin
            for (int unsigned y = y0; y <= y1; y++) begin
                for (int unsigned x = x0; x <= x1; x++) begin
                    if (voxel_mem[voxel_addr(x, y, z)] < centre) begin
                        below++;
                    end
                end
            end
        end
        count = (x1 - x0 + 1) * (y1 - y0 + 1) * (z1 - z0 + 1);
        res.rank_fraction = FRAC_W'((64'(below) << 16) / count);
        res.below_count   = CNT_W'(below);
        res.window_size   = CNT_W'(count);
        res.bad_coord     = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string field, int want, int got);
        $display("%0t rank mismatch on %s: expected %0d, got %0d", $time, field, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_rank_result got, want;
        int unsigned  px, py, pz;
        if (!i_rst_n) begin
            dim_x  = clamp_dim(SIZE_W'(SIZE_RST_RAW));
            dim_y  = clamp_dim(SIZE_W'(SIZE_RST_RAW));
            dim_z  = clamp_dim(SIZE_W'(SIZE_RST_RAW));
            radius = RAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE_X:        dim_x = clamp_dim(i_cfg_data);
                CFG_SIZE_Y:        dim_y = clamp_dim(i_cfg_data);
                CFG_SIZE_Z:        dim_z = clamp_dim(i_cfg_data);
                CFG_WINDOW_RADIUS: begin
                    radius = (i_cfg_data[RAD_W-1:0] > DEF_MAX_RADIUS) ?
                             DEF_MAX_RADIUS : i_cfg_data[RAD_W-1:0];
                end
                default: ;
            endcase
        end

        // Results are retired before the item of the same edge is predicted.
        if (i_rst_n && i_out.valid && i_out.ready) begin
            got.rank_fraction = i_out.rank_fraction;
            got.below_count   = i_out.below_count;
            got.window_size   = i_out.window_size;
            got.bad_coord     = i_out.bad_coord;
            if (expected_ranks.size() == 0) begin
                $display("%0t result with none expected: fraction %0d below %0d size %0d",
                         $time, got.rank_fraction, got.below_count, got.window_size);
                errors++;
            end else begin
                want = expected_ranks.pop_front();
                if (got.rank_fraction !== want.rank_fraction)
                    report_mismatch("rank_fraction", want.rank_fraction, got.rank_fraction);
                if (got.below_count !== want.below_count)
                    report_mismatch("below_count", want.below_count, got.below_count);
                if (got.window_size !== want.window_size)
                    report_mismatch("window_size", want.window_size, got.window_size);
                if (got.bad_coord !== want.bad_coord)
                    report_mismatch("bad_coord", want.bad_coord, got.bad_coord);
            end
        end

        if (i_rst_n && i_in.valid && i_in.ready) begin
            px = i_in.pos_x;
            py = i_in.pos_y;
            pz = i_in.pos_z;
            if (px >= dim_x || py >= dim_y || pz >= dim_z) begin
                want = '0;
                want.bad_coord = 1'b1;
                expected_ranks = {expected_ranks, want};
            end else if (i_in.cmd == CMD_WRITE) begin
                voxel_mem[voxel_addr(px, py, pz)] = i_in.voxel_value;
            end else begin
                want = rank_of_voxel(px, py, pz);
                expected_ranks = {expected_ranks, want};
            end
        end

        open_count = expected_ranks.size();
    end

endmodule

[verif/volume_local_rank_fraction_tb.sv]
module volume_local_rank_fraction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vlrf_pkg::*;
    import vlrf_tb_pkg::*;

    localparam int DIM          = DEF_MAX_DIM;
    localparam int DEPTH        = DIM * DIM * DIM;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 20000;
    localparam int RAND_PHASES  = 9;
    localparam int PHASE_ITEMS  = 9;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vlrf_in_if  in_ch ();
    vlrf_out_if out_ch ();

    int fail_count;
    int open_results;
    int send_idle_pct = 33;
    int recv_idle_pct = 49;
    int idle_cycles   = 0;

    // Voxels already written, so that no evaluate ever reads an unwritten one.
    bit          written [DEPTH];
    int unsigned vol_x, vol_y, vol_z, win_r;

    volume_local_rank_fraction u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    vlrf_rank_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_errors   (fail_count),
        .o_pending  (open_results)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[volume_local_rank_fraction] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned voxel_addr(int unsigned x, int unsigned y, int unsigned z);
        return x + DIM * (y + DIM * z);
    endfunction

    function automatic bit in_volume(int unsigned x, int unsigned y, int unsigned z);
        return (x < vol_x) && (y < vol_y) && (z < vol_z);
    endfunction

    // Extreme or small values half of the time, so that ties with the centre are common.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            1:       return 16'($urandom_range(8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_pos(int unsigned n);
        return (n == 0) ? $urandom_range(DIM - 1) : $urandom_range(n - 1);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(t_voxel_cmd op, int unsigned x, int unsigned y, int unsigned z,
                             logic [15:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= op;
        in_ch.pos_x       <= POS_W'(x);
        in_ch.pos_y       <= POS_W'(y);
        in_ch.pos_z       <= POS_W'(z);
        in_ch.voxel_value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (op == CMD_WRITE && in_volume(x, y, z)) begin
            written[voxel_addr(x, y, z)] = 1'b1;
        end
    endtask

    task automatic evaluate_at(int unsigned x, int unsigned y, int unsigned z);
        int unsigned x0, x1, y0, y1, z0, z1;
        if (in_volume(x, y, z)) begin
            x0 = (x > win_r) ? x - win_r : 0;
            x1 = (x + win_r >= vol_x) ? vol_x - 1 : x + win_r;
            y0 = (y > win_r) ? y - win_r : 0;
            y1 = (y + win_r >= vol_y) ? vol_y - 1 : y + win_r;
            z0 = (z > win_r) ? z - win_r : 0;
            z1 = (z + win_r >= vol_z) ? vol_z - 1 : z + win_r;
            for (int unsigned zz = z0; zz <= z1; zz++) begin
                for (int unsigned yy = y0; yy <= y1; yy++) begin
                    for (int unsigned xx = x0; xx <= x1; xx++) begin
                        if (!written[voxel_addr(xx, yy, zz)]) begin
                            send_item(CMD_WRITE, xx, yy, zz, pick_value());
                        end
                    end
                end
            end
        end
        send_item(CMD_EVALUATE, x, y, z, 16'($urandom));
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        case (idx)
            CFG_SIZE_X:        vol_x = (data > DIM) ? DIM : data;
            CFG_SIZE_Y:        vol_y = (data > DIM) ? DIM : data;
            CFG_SIZE_Z:        vol_z = (data > DIM) ? DIM : data;
            CFG_WINDOW_RADIUS: win_r = data[RAD_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until the block is idle before touching the registers.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (open_results != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(int unsigned sx, int unsigned sy, int unsigned sz,
                             logic [CFG_DATA_W-1:0] rad_data);
        wait_idle();
        write_reg(CFG_SIZE_X, CFG_DATA_W'(sx));
        write_reg(CFG_SIZE_Y, CFG_DATA_W'(sy));
        write_reg(CFG_SIZE_Z, CFG_DATA_W'(sz));
        write_reg(CFG_WINDOW_RADIUS, rad_data);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned sx, sy, sz, rad, sel, kind;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_SIZE_X;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_WRITE;
        in_ch.pos_x       = '0;
        in_ch.pos_y       = '0;
        in_ch.pos_z       = '0;
        in_ch.voxel_value = '0;
        vol_x = DIM;
        vol_y = DIM;
        vol_z = DIM;
        win_r = RAD_RST;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Settings after reset: full volume, radius one. Corners with extreme values.
        send_item(CMD_WRITE, 0, 0, 0, 16'h8000);
        send_item(CMD_WRITE, DIM - 1, DIM - 1, DIM - 1, 16'h7FFF);
        evaluate_at(0, 0, 0);
        evaluate_at(DIM - 1, DIM - 1, DIM - 1);
        evaluate_at(1, 1, 1);

        // Tiny volume with the widest window: the window covers all of it.
        configure(2, 3, 4, 6'b101_111);
        evaluate_at(1, 2, 3);
        send_item(CMD_WRITE, 2, 0, 0, 16'h1234);
        evaluate_at(0, 3, 0);
        evaluate_at(0, 0, 4);
        send_item(CMD_WRITE, DIM - 1, DIM - 1, DIM - 1, 16'hFFFF);

        // An empty axis makes every coordinate bad.
        configure(0, DIM, DIM, 6'b000_001);
        send_item(CMD_WRITE, 0, 0, 0, 16'h0001);
        evaluate_at(0, 0, 0);

        // Single voxel volume, window of radius zero.
        configure(1, 1, 1, 6'b111_000);
        evaluate_at(0, 0, 0);
        send_item(CMD_WRITE, 0, 0, 0, 16'h7FFF);
        evaluate_at(0, 0, 0);
        evaluate_at(0, 1, 0);

        // Oversized registers saturate; one full window and one clipped corner.
        configure(63, 33, 40, 6'b110_001);
        evaluate_at(1, 1, 1);
        evaluate_at(DIM - 1, DIM - 1, DIM - 1);

        for (int k = 0; k < RAND_PHASES; k++) begin
            if (k < RAND_PHASES / 3) begin
                send_idle_pct = 33;
                recv_idle_pct = 49;
            end else if (k < 2 * RAND_PHASES / 3) begin
                send_idle_pct = 49;
                recv_idle_pct = 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sel = $urandom_range(9);
            if (sel == 0) begin
                // Whole volume from oversized values, a window of the centre alone.
                sx  = $urandom_range(DIM, 63);
                sy  = $urandom_range(DIM, 63);
                sz  = $urandom_range(DIM, 63);
                rad = 0;
            end else if (sel == 1) begin
                sx  = $urandom_range(1);
                sy  = $urandom_range(1, 4);
                sz  = $urandom_range(1, 4);
                rad = $urandom_range(DEF_MAX_RADIUS);
            end else begin
                sx  = $urandom_range(1, 4);
                sy  = $urandom_range(1, 4);
                sz  = $urandom_range(1, 4);
                rad = $urandom_range(DEF_MAX_RADIUS);
            end
            configure(sx, sy, sz, {3'($urandom), 3'(rad)});
            repeat (PHASE_ITEMS) begin
                kind = $urandom_range(99);
                if (kind < 35) begin
                    send_item(CMD_WRITE, pick_pos(vol_x), pick_pos(vol_y), pick_pos(vol_z),
                              pick_value());
                end else if (kind < 85) begin
                    evaluate_at(pick_pos(vol_x), pick_pos(vol_y), pick_pos(vol_z));
                end else if ($urandom_range(1)) begin
                    evaluate_at($urandom_range(DIM - 1), $urandom_range(DIM - 1),
                                $urandom_range(DIM - 1));
                end else begin
                    send_item(CMD_WRITE, $urandom_range(DIM - 1), $urandom_range(DIM - 1),
                              $urandom_range(DIM - 1), pick_value());
                end
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("[volume_local_rank_fraction] OK");
        end else begin
            $display("[volume_local_rank_fraction] ERROR");
        end
        $finish;
    end

endmodule

[volume_local_rank_fraction.f]
rtl/vlrf_pkg.sv
rtl/vlrf_in_if.sv
rtl/vlrf_out_if.sv
rtl/vlrf_ram.sv
rtl/vlrf_ctrl.sv
rtl/vlrf_dp.sv
rtl/volume_local_rank_fraction.sv
rtl/vlrf_checker.sv
verif/vlrf_tb_pkg.sv
verif/vlrf_rank_checker.sv
verif/volume_local_rank_fraction_tb.sv
